/* rtl/lsdk_pkg.sv */
package lsdk_pkg;

    // Sizes of the array and of the modulus
    localparam int MAX_DIVISOR = 1024;
    localparam int MAX_LENGTH  = 65535;

    localparam int ELEM_W  = 32;
    localparam int DIV_W   = 11;
    localparam int RES_W   = 10;
    localparam int IDX_W   = 16;
    localparam int EPOCH_W = 8;
    localparam int STEP_W  = $clog2(ELEM_W);

    // Residue table
    localparam int MEM_DEPTH = MAX_DIVISOR;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Register port
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_DIVISOR_ADDR = PADDR_W'(0);
    localparam logic [DIV_W-1:0]   DIVISOR_RESET    = DIV_W'(7);
    localparam logic [DIV_W-1:0]   DIVISOR_MAX      = DIV_W'(MAX_DIVISOR);
    localparam logic [DIV_W-1:0]   DIVISOR_MIN      = DIV_W'(1);

    localparam logic [IDX_W-1:0]   MAX_INDEX        = IDX_W'(MAX_LENGTH);

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     last_item;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] best_length;
        logic             is_final;
        logic             too_long;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // latch a new word, start the remainder
        logic step;    // one remainder bit
        logic fold;    // fold remainder into running residue
        logic look;    // read the residue table
        logic commit;  // update state and emit the result word
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic index_full;
        logic sweep_busy;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/lsdk_regs.sv */
module lsdk_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsdk_pkg::PADDR_W-1:0]  paddr,
    input  logic [lsdk_pkg::PDATA_W-1:0]  pwdata,
    output logic [lsdk_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [lsdk_pkg::DIV_W-1:0]    eff_divisor,
    output logic                          cfg_clear
);
    import lsdk_pkg::*;

    logic [DIV_W-1:0] divisor_reg;
    logic             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready && (paddr == REG_DIVISOR_ADDR);

    // Hold the divisor register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= DIVISOR_RESET;
        end
        else if (wr_hit)
        begin
            divisor_reg <= pwdata[DIV_W-1:0];
        end
    end

    // A divisor write restarts the array
    assign cfg_clear = wr_hit;

    // Read back
    assign prdata = (paddr == REG_DIVISOR_ADDR) ? PDATA_W'(divisor_reg) : '0;

    // Map zero to one and clamp to the table size
    always_comb
    begin
        if (divisor_reg == '0)
        begin
            eff_divisor = DIVISOR_MIN;
        end
        else if (divisor_reg > DIVISOR_MAX)
        begin
            eff_divisor = DIVISOR_MAX;
        end
        else
        begin
            eff_divisor = divisor_reg;
        end
    end

endmodule

/* rtl/lsdk_ctrl.sv */
module lsdk_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  lsdk_pkg::dp_status_t  status,
    output lsdk_pkg::dp_cmd_t     cmd
);
    import lsdk_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RES  = 3'd2;
    localparam logic [2:0] S_LOOK = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ELEM_W - 1);

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              accept;

    // Take a word only when idle and the table is not being swept
    assign item_stall = !((state_reg == S_IDLE) && !status.sweep_busy);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = status.index_full ? S_UPD : S_DIV;
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Drive datapath commands
    always_comb
    begin
        cmd.load   = accept;
        cmd.step   = (state_reg == S_DIV);
        cmd.fold   = (state_reg == S_RES);
        cmd.look   = (state_reg == S_LOOK);
        cmd.commit = (state_reg == S_UPD) && status.out_free;
    end

endmodule

/* rtl/lsdk_dp.sv */
module lsdk_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lsdk_pkg::item_t             item,
    input  logic [lsdk_pkg::DIV_W-1:0]  eff_divisor,
    input  logic                        cfg_clear,
    input  lsdk_pkg::dp_cmd_t           cmd,
    output lsdk_pkg::dp_status_t        status,
    output lsdk_pkg::result_t           result,
    output logic                        result_valid,
    input  logic                        result_stall
);
    import lsdk_pkg::*;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [IDX_W-1:0]   first;
    } entry_t;

    localparam logic [ADDR_W-1:0]  SWEEP_LAST  = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    // Table: first index per residue, tagged with the array epoch
    entry_t mem [MEM_DEPTH];

    // Word being worked on
    logic [ELEM_W-1:0]  mag_reg;
    logic               neg_reg;
    logic               last_reg;
    logic               skip_reg;
    logic [RES_W-1:0]   rem_reg;
    logic [RES_W-1:0]   r_reg;
    entry_t             rd_data_reg;

    // Array state
    logic [RES_W-1:0]   residue_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [IDX_W-1:0]   best_reg;
    logic               ovf_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic               sweep_active_reg;
    logic [ADDR_W-1:0]  sweep_cnt_reg;

    // Output register
    result_t            result_reg;
    logic               result_valid_reg;

    logic [DIV_W-1:0]   shifted;
    logic [RES_W-1:0]   rem_next;
    logic [RES_W-1:0]   em;
    logic [DIV_W-1:0]   sum;
    logic [RES_W-1:0]   r_next;
    logic               seen;
    logic [IDX_W-1:0]   idx_inc;
    logic [IDX_W-1:0]   cand;
    logic [IDX_W-1:0]   best_next;
    logic               ovf_next;
    logic               clear_evt;
    logic               epoch_wrap;
    logic               entry_we;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    entry_t             mem_wdata;

    // Status to the controller
    assign status.index_full = (index_reg == MAX_INDEX);
    assign status.sweep_busy = sweep_active_reg;
    assign status.out_free   = !result_valid_reg || !result_stall;

    // Latch the word: magnitude and sign of the element
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg  <= item.element[ELEM_W-1];
            mag_reg  <= item.element[ELEM_W-1] ? (ELEM_W'(0) - item.element) : item.element;
            last_reg <= item.last_item;
            skip_reg <= status.index_full;
        end
        else if (cmd.step)
        begin
            mag_reg <= {mag_reg[ELEM_W-2:0], 1'b0};
        end
    end

    // Restoring remainder, one bit per cycle
    always_comb
    begin
        shifted = {rem_reg, mag_reg[ELEM_W-1]};
        if (shifted >= eff_divisor)
        begin
            rem_next = RES_W'(shifted - eff_divisor);
        end
        else
        begin
            rem_next = shifted[RES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
        end
    end

    // Map a negative remainder up, add to the running residue, reduce once
    always_comb
    begin
        if (neg_reg && (rem_reg != '0))
        begin
            em = RES_W'(eff_divisor - DIV_W'(rem_reg));
        end
        else
        begin
            em = rem_reg;
        end
        sum = DIV_W'(residue_reg) + DIV_W'(em);
        if (sum >= eff_divisor)
        begin
            r_next = RES_W'(sum - eff_divisor);
        end
        else
        begin
            r_next = sum[RES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fold)
        begin
            r_reg <= r_next;
        end
    end

    // Evaluate the table entry against the current index
    always_comb
    begin
        seen    = (rd_data_reg.tag == epoch_reg);
        idx_inc = index_reg + 1'b1;
        if (r_reg == '0)
        begin
            cand = idx_inc;
        end
        else if (seen)
        begin
            cand = index_reg - rd_data_reg.first;
        end
        else
        begin
            cand = '0;
        end
        if (skip_reg)
        begin
            best_next = best_reg;
        end
        else
        begin
            best_next = (cand > best_reg) ? cand : best_reg;
        end
        ovf_next = ovf_reg || skip_reg;
    end

    assign clear_evt  = cfg_clear || (cmd.commit && last_reg);
    assign epoch_wrap = (epoch_reg == '1);
    assign entry_we   = cmd.commit && !skip_reg && (r_reg != '0) && !seen;

    // Write port: sweep or first sighting of a residue
    always_comb
    begin
        mem_we = sweep_active_reg || entry_we;
        if (sweep_active_reg)
        begin
            mem_waddr = sweep_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_waddr       = r_reg;
            mem_wdata.tag   = epoch_reg;
            mem_wdata.first = index_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.look)
        begin
            rd_data_reg <= mem[r_reg];
        end
    end

    // Advance the array state, clear at array end or divisor write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residue_reg <= '0;
            index_reg   <= '0;
            best_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (clear_evt)
        begin
            residue_reg <= '0;
            index_reg   <= '0;
            best_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (!skip_reg)
            begin
                residue_reg <= r_reg;
                index_reg   <= idx_inc;
            end
            best_reg <= best_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Epoch marks entries of the current array; a wrap forces a sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg        <= EPOCH_FIRST;
            sweep_active_reg <= 1'b1;
            sweep_cnt_reg    <= '0;
        end
        else
        begin
            if (clear_evt)
            begin
                epoch_reg <= epoch_wrap ? EPOCH_FIRST : epoch_reg + 1'b1;
            end
            if (clear_evt && epoch_wrap)
            begin
                sweep_active_reg <= 1'b1;
                sweep_cnt_reg    <= '0;
            end
            else if (sweep_active_reg)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    sweep_active_reg <= 1'b0;
                end
            end
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg.best_length <= best_next;
            result_reg.is_final    <= last_reg;
            result_reg.too_long    <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

/* rtl/longest_subarray_divisible_by_k_top.sv */
// Flow: a taken word runs through the bit-serial remainder (S_DIV), fold (S_RES), table read
//   (S_LOOK) and commit (S_UPD), which registers the result word; a word that comes when the
//   array is past its maximum length goes straight to S_UPD. A new word is taken only after
//   the last has committed; a waiting result word does not block the next input.
// Reset: asynchronous, active low; divisor returns to 7 and the residue table is swept; no word
//   is taken meanwhile; the same sweep runs after every 255th array end or divisor write.
module longest_subarray_divisible_by_k_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  lsdk_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output lsdk_pkg::result_t             result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsdk_pkg::PADDR_W-1:0]  paddr,
    input  logic [lsdk_pkg::PDATA_W-1:0]  pwdata,
    output logic [lsdk_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import lsdk_pkg::*;

    logic [DIV_W-1:0] eff_divisor;
    logic             cfg_clear;
    dp_cmd_t          cmd;
    dp_status_t       status;

    lsdk_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .eff_divisor (eff_divisor),
        .cfg_clear   (cfg_clear)
    );

    lsdk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    lsdk_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .eff_divisor  (eff_divisor),
        .cfg_clear    (cfg_clear),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule
